// File: rtl/ris_pkg.sv
// package: constants, codes and types shared by the status response block
`timescale 1ns / 1ps
package ris_pkg;

  localparam int IMAGE_WORDS = 256;
  localparam int MAX_BITS    = 256;

  localparam int IMG_AW     = $clog2(IMAGE_WORDS);
  localparam int IMAGE_BITS = IMAGE_WORDS * 16;
  localparam int QTY_W      = $clog2(MAX_BITS + 1);
  localparam int NB_W       = $clog2(MAX_BITS / 8 + 2);
  localparam int HCNT_W     = 4;

  localparam logic [HCNT_W-1:0] HDR_LAST  = HCNT_W'(8);
  localparam logic [7:0]        LEN_BASE  = 8'h03;
  localparam logic [7:0]        FLEN_BASE = 8'h09;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_QTY  = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_HDR,
    S_LOAD,
    S_LATCH,
    S_GATHER
  } seq_state_t;

  typedef struct packed {
    logic              en;
    logic [IMG_AW-1:0] addr;
    logic [15:0]       data;
  } img_wr_t;

  typedef struct packed {
    logic              en;
    logic [IMG_AW-1:0] addr;
  } img_rd_t;

endpackage

// File: rtl/ris_req_if.sv
// interface: request and image write words into the block
`timescale 1ns / 1ps
interface ris_req_if;
  import ris_pkg::*;

  logic        valid;
  logic        ready;
  cmd_t        command;
  logic [7:0]  word_index;
  logic [15:0] word_value;
  logic [15:0] transaction_id;
  logic [15:0] protocol_id;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [10:0] bit_quantity;

  modport source (
    output valid, command, word_index, word_value, transaction_id, protocol_id,
           unit_id, function_code, start_address, bit_quantity,
    input  ready
  );

  modport sink (
    input  valid, command, word_index, word_value, transaction_id, protocol_id,
           unit_id, function_code, start_address, bit_quantity,
    output ready
  );
endinterface

// File: rtl/ris_resp_if.sv
// interface: response frame words out of the block
`timescale 1ns / 1ps
interface ris_resp_if;
  import ris_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic [7:0] frame_length;
  status_t    status;

  modport source (
    output valid, tx_byte, last_byte, frame_length, status,
    input  ready
  );

  modport sink (
    input  valid, tx_byte, last_byte, frame_length, status,
    output ready
  );
endinterface

// File: rtl/ris_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module ris_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ris_image.sv
// input status image: ram plus per-word valid bits so unwritten words read as zero
`timescale 1ns / 1ps
module ris_image (
  input  logic             clk,
  input  logic             rst,
  input  ris_pkg::img_wr_t wr,
  input  ris_pkg::img_rd_t rd,
  output logic [15:0]      rdata
);
  import ris_pkg::*;

  logic [IMAGE_WORDS-1:0] written;
  logic                   rd_written;
  logic [15:0]            ram_rdata;

  ris_ram #(
    .WIDTH (16),
    .DEPTH (IMAGE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_written <= written[rd.addr];
      end
    end
  end

  assign rdata = rd_written ? ram_rdata : 16'h0000;

endmodule

// File: rtl/ris_seq.sv
// sequencer: checks request, emits header, gathers bits one per cycle if unstalled
`timescale 1ns / 1ps
module ris_seq (
  input  logic             clk,
  input  logic             rst,
  ris_req_if.sink          req,
  ris_resp_if.source       resp,
  output ris_pkg::img_wr_t wr,
  output ris_pkg::img_rd_t rd,
  input  logic [15:0]      img_rdata
);
  import ris_pkg::*;

  seq_state_t        state, state_next;
  logic [HCNT_W-1:0] hcnt, hcnt_next;
  logic [15:0]       tid, tid_next;
  logic [15:0]       pid, pid_next;
  logic [7:0]        uid, uid_next;
  logic [7:0]        fc, fc_next;
  status_t           stat, stat_next;
  logic [QTY_W-1:0]  qty, qty_next;
  logic [NB_W-1:0]   nbytes, nbytes_next;
  logic [IMG_AW-1:0] waddr, waddr_next;
  logic [3:0]        boff, boff_next;
  logic [15:0]       wreg, wreg_next;
  logic [7:0]        pack_byte, pack_byte_next;
  logic [QTY_W-1:0]  bit_counter, bit_counter_next;

  logic        out_valid, out_valid_next;
  logic [7:0]  out_byte, out_byte_next;
  logic        out_last, out_last_next;
  logic [7:0]  out_flen, out_flen_next;
  status_t     out_stat, out_stat_next;

  logic        can_emit;
  logic [7:0]  flen;
  logic [7:0]  hdr_byte;
  logic        bad_qty, bad_addr;
  logic [16:0] end_bit;
  logic [15:0] first_bit;
  logic        cur_bit;
  logic [7:0]  byte_now;
  logic        last_bit, byte_done;

  assign req.ready = (state == S_IDLE);
  assign can_emit  = !out_valid || resp.ready;
  assign flen      = FLEN_BASE + 8'(nbytes);

  assign bad_qty   = (req.bit_quantity == 11'd0) || (32'(req.bit_quantity) > MAX_BITS);
  assign end_bit   = 17'(req.start_address) - 17'd1 + 17'(req.bit_quantity);
  assign bad_addr  = (req.start_address == 16'd0) || (32'(end_bit) > IMAGE_BITS);
  assign first_bit = req.start_address - 16'd1;

  assign cur_bit   = wreg[boff];
  assign byte_now  = pack_byte | (8'(cur_bit) << bit_counter[2:0]);
  assign last_bit  = (bit_counter + QTY_W'(1)) == qty;
  assign byte_done = (bit_counter[2:0] == 3'd7) || last_bit;

  always_comb begin
    unique case (hcnt)
      4'd0:    hdr_byte = tid[15:8];
      4'd1:    hdr_byte = tid[7:0];
      4'd2:    hdr_byte = pid[15:8];
      4'd3:    hdr_byte = pid[7:0];
      4'd4:    hdr_byte = 8'h00;
      4'd5:    hdr_byte = LEN_BASE + 8'(nbytes);
      4'd6:    hdr_byte = uid;
      4'd7:    hdr_byte = fc;
      4'd8:    hdr_byte = 8'(nbytes);
      default: hdr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    hcnt        <= hcnt_next;
    tid         <= tid_next;
    pid         <= pid_next;
    uid         <= uid_next;
    fc          <= fc_next;
    stat        <= stat_next;
    qty         <= qty_next;
    nbytes      <= nbytes_next;
    waddr       <= waddr_next;
    boff        <= boff_next;
    wreg        <= wreg_next;
    pack_byte   <= pack_byte_next;
    bit_counter <= bit_counter_next;
    out_byte    <= out_byte_next;
    out_last    <= out_last_next;
    out_flen    <= out_flen_next;
    out_stat    <= out_stat_next;
  end

  always_comb begin
    state_next       = state;
    hcnt_next        = hcnt;
    tid_next         = tid;
    pid_next         = pid;
    uid_next         = uid;
    fc_next          = fc;
    stat_next        = stat;
    qty_next         = qty;
    nbytes_next      = nbytes;
    waddr_next       = waddr;
    boff_next        = boff;
    wreg_next        = wreg;
    pack_byte_next   = pack_byte;
    bit_counter_next = bit_counter;
    out_valid_next   = out_valid && !resp.ready;
    out_byte_next    = out_byte;
    out_last_next    = out_last;
    out_flen_next    = out_flen;
    out_stat_next    = out_stat;
    wr.en            = 1'b0;
    wr.addr          = IMG_AW'(req.word_index);
    wr.data          = req.word_value;
    rd.en            = 1'b0;
    rd.addr          = waddr;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_WRITE) begin
            wr.en = 32'(req.word_index) < IMAGE_WORDS;
          end else begin
            tid_next         = req.transaction_id;
            pid_next         = req.protocol_id;
            uid_next         = req.unit_id;
            fc_next          = req.function_code;
            qty_next         = QTY_W'(req.bit_quantity);
            nbytes_next      = NB_W'((12'(req.bit_quantity) + 12'd7) >> 3);
            waddr_next       = IMG_AW'(first_bit >> 4);
            boff_next        = first_bit[3:0];
            hcnt_next        = '0;
            pack_byte_next   = 8'h00;
            bit_counter_next = '0;
            if (bad_qty) begin
              stat_next  = ST_BAD_QTY;
              state_next = S_ERR;
            end else if (bad_addr) begin
              stat_next  = ST_BAD_ADDR;
              state_next = S_ERR;
            end else begin
              stat_next  = ST_OK;
              state_next = S_HDR;
            end
          end
        end
      end
      S_ERR: begin
        if (can_emit) begin
          out_valid_next = 1'b1;
          out_byte_next  = 8'h00;
          out_last_next  = 1'b1;
          out_flen_next  = 8'h00;
          out_stat_next  = stat;
          state_next     = S_IDLE;
        end
      end
      S_HDR: begin
        if (can_emit) begin
          out_valid_next = 1'b1;
          out_byte_next  = hdr_byte;
          out_last_next  = 1'b0;
          out_flen_next  = flen;
          out_stat_next  = ST_OK;
          hcnt_next      = hcnt + HCNT_W'(1);
          if (hcnt == HDR_LAST) begin
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        rd.en      = 1'b1;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        wreg_next  = img_rdata;
        state_next = S_GATHER;
      end
      S_GATHER: begin
        if (!byte_done || can_emit) begin
          bit_counter_next = bit_counter + QTY_W'(1);
          boff_next        = boff + 4'd1;
          pack_byte_next   = byte_now;
          if (byte_done) begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_now;
            out_last_next  = last_bit;
            out_flen_next  = flen;
            out_stat_next  = ST_OK;
            pack_byte_next = 8'h00;
          end
          if (last_bit) begin
            state_next = S_IDLE;
          end else if (boff == 4'd15) begin
            waddr_next = waddr + IMG_AW'(1);
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign resp.valid        = out_valid;
  assign resp.tx_byte      = out_byte;
  assign resp.last_byte    = out_last;
  assign resp.frame_length = out_flen;
  assign resp.status       = out_stat;

endmodule

// File: rtl/read_input_status_response.sv
// top level: modbus read discrete inputs response generator
//
// req channel (sink): a word with command write stores word_value into image
// word word_index and gives no result; indexes beyond the image
// are dropped. A word with command read asks for bit_quantity status bits
// starting at start_address (counted from one).
// resp channel (source): one frame byte per word, last_byte on the final one.
// A good frame is 9 header bytes and ceil(bit_quantity/8) data bytes, all
// carrying frame_length; a bad quantity or address gives one zero word with
// status set and last_byte high.
// A taken good read moves the sequencer to the header state, which registers
// the first header byte in the output register. A read keeps the block busy for
// the header, the single gather step (one bit a cycle unless output stalls) and
// an image fetch (load, latch) per word. ready is high only while idle.
// Reset clears the sequencer, the output register and the written marks of the
// image, so every image word reads as zero until written.
// A receiver stall holds the output register; the sequencer waits behind it.
`timescale 1ns / 1ps
module read_input_status_response (
  input  logic       clk,
  input  logic       rst,
  ris_req_if.sink    req,
  ris_resp_if.source resp
);
  import ris_pkg::*;

  img_wr_t     wr;
  img_rd_t     rd;
  logic [15:0] img_rdata;

  ris_image u_image (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .rd    (rd),
    .rdata (img_rdata)
  );

  ris_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .resp      (resp),
    .wr        (wr),
    .rd        (rd),
    .img_rdata (img_rdata)
  );

`ifndef NO_ASSERTIONS
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.command == CMD_READ |=> !req.ready)
    else $error("ready stayed high after a read request");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.command == CMD_WRITE |=> req.ready)
    else $error("write word left the block busy");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    resp.valid && resp.status != ST_OK |->
      resp.last_byte && resp.tx_byte == 8'h00 && resp.frame_length == 8'h00)
    else $error("error word is not a lone zero word");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    resp.valid && resp.status == ST_OK |-> resp.frame_length >= 8'd10)
    else $error("good frame with too short frame_length");
`endif

endmodule
